// ===== src/ens_pkg.sv =====
// Shared types and constants for the eight-neighbor mean stencil unit.
// No dependencies.
`default_nettype none

package ens_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int SUM_W       = SAMPLE_BITS + 3;
    localparam int COL_W       = 11;
    localparam int ROW_W       = 16;
    localparam int COL_OUT_W   = 10;
    localparam int RL_W        = 11;
    localparam int RC_W        = 16;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic REG_ROW_LENGTH = 1'b0;
    localparam logic REG_ROW_COUNT  = 1'b1;

    localparam logic [RL_W-1:0] ROW_LENGTH_RESET = 11'd1024;
    localparam logic [RC_W-1:0] ROW_COUNT_RESET  = 16'd1024;
    localparam logic [RL_W-1:0] MIN_ROW_LENGTH   = 11'd3;
    localparam logic [RC_W-1:0] MIN_ROW_COUNT    = 16'd3;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   frame_start;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] mean;
        logic [ROW_W-1:0]       row_index;
        logic [COL_OUT_W-1:0]   col_index;
        logic                   last_of_frame;
    } out_item_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             end_row;
        logic             end_frame;
        logic             interior;
    } pos_t;

endpackage

`default_nettype wire

// ===== src/ens_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none

module ens_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/ens_pos.sv =====
// Grid position counters: column/row of the incoming sample and row/frame ends.
// Depends on ens_pkg.
`default_nettype none

module ens_pos #(
    parameter int MAX_ROW_LENGTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     advance,
    input  wire logic                     frame_start,
    input  wire logic [ens_pkg::RL_W-1:0] row_length,
    input  wire logic [ens_pkg::RC_W-1:0] row_count,
    output ens_pkg::pos_t                 pos
);

    import ens_pkg::*;

    localparam int CAP = (MAX_ROW_LENGTH > 2047) ? 2047 : MAX_ROW_LENGTH;
    localparam logic [RL_W-1:0] CAP_LEN = RL_W'(CAP);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [RL_W-1:0]  eff_len;
    logic [RC_W-1:0]  eff_cnt;

    always_comb
    begin
        if (row_length < MIN_ROW_LENGTH)
        begin
            eff_len = MIN_ROW_LENGTH;
        end
        else if (row_length > CAP_LEN)
        begin
            eff_len = CAP_LEN;
        end
        else
        begin
            eff_len = row_length;
        end
        eff_cnt = (row_count < MIN_ROW_COUNT) ? MIN_ROW_COUNT : row_count;

        pos.col       = frame_start ? '0 : col_reg;
        pos.row       = frame_start ? '0 : row_reg;
        pos.end_row   = ({1'b0, pos.col} + 12'd1) >= {1'b0, eff_len};
        pos.end_frame = pos.end_row && (({1'b0, pos.row} + 17'd1) >= {1'b0, eff_cnt});
        pos.interior  = (pos.row >= 16'd2) && (pos.col >= 11'd2);

        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (pos.end_frame)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (pos.end_row)
            begin
                col_next = '0;
                row_next = pos.row + 16'd1;
            end
            else
            begin
                col_next = pos.col + 11'd1;
                row_next = pos.row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/ens_win.sv =====
// Two-column window registers and the eight-neighbor adder (center excluded).
// Depends on ens_pkg.
`default_nettype none

module ens_win (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      shift,
    input  wire ens_pkg::sample_t          top,
    input  wire ens_pkg::sample_t          mid,
    input  wire ens_pkg::sample_t          bot,
    output logic      [ens_pkg::SUM_W-1:0] sum
);

    import ens_pkg::*;

    // [0..2]: column c-2 (top, mid, bottom); [3..5]: column c-1
    sample_t win_reg [6];

    always_comb
    begin
        sum = SUM_W'(win_reg[0]) + SUM_W'(win_reg[1]) + SUM_W'(win_reg[2])
            + SUM_W'(win_reg[3]) + SUM_W'(win_reg[5])
            + SUM_W'(top) + SUM_W'(mid) + SUM_W'(bot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (shift)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= bot;
        end
    end

endmodule

`default_nettype wire

// ===== src/eight_neighbour_mean_stencil_unit.sv =====
// Top level of the eight-neighbor mean 3x3 stencil: APB registers, line-store pipeline.
// Depends on ens_pkg, ens_ram, ens_pos, ens_win.
//
//  port group | dir | transaction moves
//  -----------+-----+-----------------------------------------------
//  in_*       | in  | one grid sample + frame_start, row-major
//  out_*      | out | mean, row_index, col_index, last_of_frame
//  APB        | in  | writes/reads of row_length (0x0), row_count (0x4)
//
// One sample per cycle sustained while the output is not stalled; the sample that
// completes a window passes the line-store read stage, then the output register.
// Line stores are one read and one write per cycle; same-entry overlap is forwarded.
// Reset clears counters and window; line stores are not cleared.
// out_stall holds the result; in_stall rises only once the read stage is also full.
`default_nettype none

module eight_neighbour_mean_stencil_unit #(
    parameter int MAX_ROW_LENGTH = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire ens_pkg::in_item_t              in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output ens_pkg::out_item_t                  out_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ens_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [ens_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [ens_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);

    import ens_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ROW_LENGTH);

    logic [RL_W-1:0] row_length_reg;
    logic [RC_W-1:0] row_count_reg;
    logic            reg_idx;
    logic            cfg_write;

    pos_t pos;
    logic in_fire;
    logic s1_fire;

    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    sample_t           s1_smp_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic              s1_inter_reg;
    logic              s1_last_reg;

    logic              fwd_reg;
    sample_t           fwd_upper_reg;
    sample_t           fwd_middle_reg;

    logic [ADDR_W-1:0] rd_addr;
    sample_t           upper_rdata;
    sample_t           middle_rdata;
    sample_t           top_val;
    sample_t           mid_val;
    logic [SUM_W-1:0]  sum;

    logic              out_valid_reg;
    out_item_t         out_data_reg;

    // APB
    assign pready    = 1'b1;
    assign reg_idx   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_idx)
            REG_ROW_LENGTH: prdata = APB_DATA_W'(row_length_reg);
            REG_ROW_COUNT:  prdata = APB_DATA_W'(row_count_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= ROW_LENGTH_RESET;
            row_count_reg  <= ROW_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_ROW_LENGTH: row_length_reg <= pwdata[RL_W-1:0];
                REG_ROW_COUNT:  row_count_reg  <= pwdata[RC_W-1:0];
                default:        ;
            endcase
        end
    end

    // handshake
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_fire  = in_valid && !in_stall;

    ens_pos #(
        .MAX_ROW_LENGTH(MAX_ROW_LENGTH)
    ) u_pos (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (in_fire),
        .frame_start(in_data.frame_start),
        .row_length (row_length_reg),
        .row_count  (row_count_reg),
        .pos        (pos)
    );

    assign rd_addr = ADDR_W'(pos.col);

    ens_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(MAX_ROW_LENGTH)
    ) u_upper (
        .clk  (clk),
        .we   (s1_fire),
        .waddr(s1_addr_reg),
        .wdata(mid_val),
        .re   (in_fire),
        .raddr(rd_addr),
        .rdata(upper_rdata)
    );

    ens_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(MAX_ROW_LENGTH)
    ) u_middle (
        .clk  (clk),
        .we   (s1_fire),
        .waddr(s1_addr_reg),
        .wdata(s1_smp_reg),
        .re   (in_fire),
        .raddr(rd_addr),
        .rdata(middle_rdata)
    );

    // read issued while the same entry was being written: take the written values
    assign top_val = fwd_reg ? fwd_upper_reg  : upper_rdata;
    assign mid_val = fwd_reg ? fwd_middle_reg : middle_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= s1_fire && (s1_addr_reg == rd_addr);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
                fwd_reg      <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_addr_reg    <= rd_addr;
            s1_smp_reg     <= in_data.sample;
            s1_col_reg     <= pos.col;
            s1_row_reg     <= pos.row;
            s1_inter_reg   <= pos.interior;
            s1_last_reg    <= pos.end_frame;
            fwd_upper_reg  <= mid_val;
            fwd_middle_reg <= s1_smp_reg;
        end
    end

    ens_win u_win (
        .clk  (clk),
        .rst_n(rst_n),
        .shift(s1_fire),
        .top  (top_val),
        .mid  (mid_val),
        .bot  (s1_smp_reg),
        .sum  (sum)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= s1_inter_reg;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_inter_reg)
        begin
            out_data_reg.mean          <= sum[SUM_W-1:3];
            out_data_reg.row_index     <= s1_row_reg - 16'd1;
            out_data_reg.col_index     <= COL_OUT_W'(s1_col_reg - 11'd1);
            out_data_reg.last_of_frame <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_frame_start_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.frame_start) |=>
            (s1_valid_reg && s1_col_reg == '0 && s1_row_reg == '0))
        else $error("frame_start did not restart at the origin");

    a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> s1_valid_reg)
        else $error("forwarding flagged with no item in the read stage");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_fire && s1_inter_reg))
        else $error("result produced without an interior transaction");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && s1_valid_reg) |=> $stable(s1_smp_reg))
        else $error("read stage overwritten while output blocked");

endmodule

`default_nettype wire

// ===== dv/tb_eight_neighbour_mean_stencil_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for eight_neighbour_mean_stencil_unit: directed and random grids.
// A local predictor of the line stores and window sets the expected means.
// Depends on ens_pkg and the RTL under src/.
module tb_eight_neighbour_mean_stencil_unit;
    import ens_pkg::*;

    localparam int          MAX_W           = 1024;
    localparam int          SETTLE_CYCLES   = 8;
    localparam int          WATCHDOG_LIMIT  = 5000;
    localparam int          RANDOM_ITEMS    = 200;
    localparam int          HOLD_OFF_CYCLES = 400;
    localparam int unsigned GAP_LIMITS [3]  = '{0, 3, 18};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    eight_neighbour_mean_stencil_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // predictor state
    sample_t           upper_line [MAX_W];
    sample_t           middle_line [MAX_W];
    sample_t           window_cols [6];
    int unsigned       col_pos;
    int unsigned       row_pos;
    logic [RL_W-1:0]   row_length_reg;
    logic [RC_W-1:0]   row_count_reg;

    out_item_t         pending_means [$];
    int unsigned       mean_errors;
    int unsigned       samples_sent;
    int unsigned       means_checked;
    int unsigned       frames_done;
    int unsigned       tx_max_gap;
    int unsigned       rx_max_gap;
    int unsigned       rx_hold;
    int unsigned       idle_cycles;

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic int unsigned eff_width(input logic [RL_W-1:0] rl);
        if (rl < MIN_ROW_LENGTH)
            return 32'(MIN_ROW_LENGTH);
        if (32'(rl) > MAX_W)
            return MAX_W;
        return 32'(rl);
    endfunction

    function automatic int unsigned eff_height(input logic [RC_W-1:0] rc);
        if (rc < MIN_ROW_COUNT)
            return 32'(MIN_ROW_COUNT);
        return 32'(rc);
    endfunction

    function automatic sample_t random_sample();
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return '1;
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Advances the predictor by one sample; returns 1 when a mean is due.
    function automatic bit compute_neighbour_mean(input in_item_t it, output out_item_t res);
        int unsigned           w;
        int unsigned           h;
        int unsigned           c;
        int unsigned           r;
        int unsigned           idx;
        int unsigned           ri;
        int unsigned           ci;
        sample_t               top;
        sample_t               mid;
        sample_t               smp;
        logic [SUM_W-1:0]      sum;
        bit                    end_row;
        bit                    end_frame;
        bit                    hit;
        w = eff_width(row_length_reg);
        h = eff_height(row_count_reg);
        smp = it.sample;
        if (it.frame_start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        idx = c % MAX_W;
        top = upper_line[idx];
        mid = middle_line[idx];
        upper_line[idx] = mid;
        middle_line[idx] = smp;
        end_row = (c + 1 >= w);
        end_frame = end_row && (r + 1 >= h);
        hit = (r >= 2) && (c >= 2);
        res = '0;
        if (hit)
        begin
            sum = SUM_W'(window_cols[0]) + SUM_W'(window_cols[1]) + SUM_W'(window_cols[2])
                + SUM_W'(window_cols[3]) + SUM_W'(window_cols[5])
                + SUM_W'(top) + SUM_W'(mid) + SUM_W'(smp);
            ri = r - 1;
            ci = c - 1;
            res.mean = sum[SUM_W-1:3];
            res.row_index = ri[ROW_W-1:0];
            res.col_index = ci[COL_OUT_W-1:0];
            res.last_of_frame = end_frame;
        end
        window_cols[0] = window_cols[3];
        window_cols[1] = window_cols[4];
        window_cols[2] = window_cols[5];
        window_cols[3] = top;
        window_cols[4] = mid;
        window_cols[5] = smp;
        if (end_frame)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        else if (end_row)
        begin
            col_pos = 0;
            row_pos = (r + 1) & 16'hFFFF;
        end
        else
        begin
            col_pos = c + 1;
        end
        return hit;
    endfunction

    task automatic report_mismatch(input string msg);
        mean_errors++;
        if (mean_errors <= 40)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic send_sample(input sample_t smp, input bit fs);
        in_item_t    it;
        out_item_t   res;
        int unsigned gap;
        gap = $urandom_range(tx_max_gap, 0);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.sample = smp;
        it.frame_start = fs;
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (in_stall);
        samples_sent++;
        if (compute_neighbour_mean(it, res))
            pending_means.push_back(res);
    endtask

    task automatic send_random_samples(input int unsigned count, input bit fs_first);
        int unsigned k;
        for (k = 0; k < count; k++)
            send_sample(random_sample(), fs_first && (k == 0));
    endtask

    // Waits until every expected mean has come out, then lets the pipeline settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_transfer(input bit wr, input logic idx, input logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
    endtask

    task automatic check_register(input logic idx, input logic [APB_DATA_W-1:0] exp);
        logic [APB_DATA_W-1:0] got;
        apb_transfer(1'b0, idx, '0, got);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== exp)
            report_mismatch($sformatf("register %0d read %0h exp %0h", idx, got, exp));
    endtask

    task automatic write_register(input logic idx, input int unsigned value);
        logic [APB_DATA_W-1:0] wdata;
        logic [APB_DATA_W-1:0] unused;
        wdata = $urandom;
        if (idx == REG_ROW_LENGTH)
        begin
            wdata[RL_W-1:0] = value[RL_W-1:0];
            row_length_reg = value[RL_W-1:0];
        end
        else
        begin
            wdata[RC_W-1:0] = value[RC_W-1:0];
            row_count_reg = value[RC_W-1:0];
        end
        apb_transfer(1'b1, idx, wdata, unused);
        if (idx == REG_ROW_LENGTH)
            check_register(idx, APB_DATA_W'(row_length_reg));
        else
            check_register(idx, APB_DATA_W'(row_count_reg));
    endtask

    task automatic set_geometry(input int unsigned rl, input int unsigned rc);
        drain_results();
        write_register(REG_ROW_LENGTH, rl);
        write_register(REG_ROW_COUNT, rc);
    endtask

    task automatic test_reset_values();
        check_register(REG_ROW_LENGTH, APB_DATA_W'(ROW_LENGTH_RESET));
        check_register(REG_ROW_COUNT, APB_DATA_W'(ROW_COUNT_RESET));
    endtask

    // smallest grid: full-scale mean, center excluded, wrap without frame_start
    task automatic test_min_grid();
        int unsigned k;
        tx_max_gap = 18;
        rx_max_gap = 18;
        set_geometry(3, 3);
        for (k = 0; k < 9; k++)
            send_sample('1, k == 0);
        for (k = 0; k < 9; k++)
            send_sample((k == 4) ? '1 : '0, 1'b0);
        send_random_samples(9, 1'b1);
    endtask

    task automatic test_register_clamp();
        tx_max_gap = 3;
        rx_max_gap = 3;
        set_geometry(0, 0);
        send_random_samples(9, 1'b1);
        set_geometry(2, 2);
        send_random_samples(9, 1'b1);
        set_geometry(1, 1);
        send_random_samples(10, 1'b1);
    endtask

    task automatic test_frame_restart();
        tx_max_gap = 18;
        rx_max_gap = 0;
        set_geometry(5, 5);
        send_random_samples(13, 1'b1);
        send_random_samples(25, 1'b1);
    endtask

    // shrink row length and row count while a frame is in flight
    task automatic test_midframe_shrink();
        tx_max_gap = 2;
        rx_max_gap = 18;
        set_geometry(8, 6);
        send_random_samples(29, 1'b1);
        set_geometry(4, 4);
        send_random_samples(20, 1'b0);
    endtask

    // oversized row length clamps to the full line store; first interior row only
    task automatic test_wide_rows();
        tx_max_gap = 2;
        rx_max_gap = 2;
        set_geometry(2047, 3);
        send_random_samples(2 * 1024 + 6, 1'b1);
    endtask

    task automatic test_tall_frame();
        tx_max_gap = 0;
        rx_max_gap = 0;
        set_geometry(3, 65535);
        send_random_samples(40, 1'b1);
    endtask

    task automatic test_backpressure();
        tx_max_gap = 0;
        rx_max_gap = 0;
        set_geometry(6, 20);
        rx_hold = HOLD_OFF_CYCLES;
        send_random_samples(120, 1'b1);
    endtask

    task automatic test_random_frames();
        int unsigned sent;
        int unsigned rl;
        int unsigned rc;
        int unsigned total;
        int unsigned k;
        bit          need_start;
        bit          fs;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            rl = ($urandom_range(7, 0) == 0) ? $urandom_range(2, 0) : $urandom_range(24, 3);
            rc = ($urandom_range(7, 0) == 0) ? $urandom_range(2, 0) : $urandom_range(12, 3);
            drain_results();
            // growing rows mid-frame would read line-store entries never written
            need_start = (eff_width(rl[RL_W-1:0]) > eff_width(row_length_reg))
                      && (col_pos != 0 || row_pos != 0);
            write_register(REG_ROW_LENGTH, rl);
            write_register(REG_ROW_COUNT, rc);
            tx_max_gap = GAP_LIMITS[$urandom_range(2, 0)];
            rx_max_gap = GAP_LIMITS[$urandom_range(2, 0)];
            total = eff_width(row_length_reg) * eff_height(row_count_reg) * $urandom_range(2, 1);
            if ($urandom_range(3, 0) == 0)
                total = $urandom_range(total, 1);
            if (total > RANDOM_ITEMS - sent)
                total = RANDOM_ITEMS - sent;
            for (k = 0; k < total; k++)
            begin
                if (k == 0)
                    fs = need_start || ($urandom_range(1, 0) == 1);
                else
                    fs = ($urandom_range(63, 0) == 0);
                send_sample(random_sample(), fs);
            end
            sent += total;
        end
    endtask

    // result sink: random stall per transaction, plus one long hold-off on request
    initial begin : result_sink
        int unsigned n;
        forever
        begin
            if (rx_hold != 0)
            begin
                n = rx_hold;
                rx_hold = 0;
            end
            else
            begin
                n = $urandom_range(rx_max_gap, 0);
            end
            if (n != 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        out_item_t exp;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_means.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result row %0d col %0d",
                                          out_data.row_index, out_data.col_index));
            end
            else
            begin
                exp = pending_means.pop_front();
                means_checked++;
                if (exp.last_of_frame)
                    frames_done++;
                if (out_data.mean !== exp.mean)
                    report_mismatch($sformatf("mean got %0h exp %0h at row %0d col %0d",
                                              out_data.mean, exp.mean,
                                              exp.row_index, exp.col_index));
                if (out_data.row_index !== exp.row_index)
                    report_mismatch($sformatf("row_index got %0d exp %0d",
                                              out_data.row_index, exp.row_index));
                if (out_data.col_index !== exp.col_index)
                    report_mismatch($sformatf("col_index got %0d exp %0d at row %0d",
                                              out_data.col_index, exp.col_index,
                                              exp.row_index));
                if (out_data.last_of_frame !== exp.last_of_frame)
                    report_mismatch($sformatf("last_of_frame got %0b exp %0b at row %0d col %0d",
                                              out_data.last_of_frame, exp.last_of_frame,
                                              exp.row_index, exp.col_index));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TIMEOUT: no transaction for %0d cycles, %0d means outstanding",
                     idle_cycles, pending_means.size());
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        mean_errors = 0;
        samples_sent = 0;
        means_checked = 0;
        frames_done = 0;
        tx_max_gap = 0;
        rx_max_gap = 0;
        rx_hold = 0;
        idle_cycles = 0;
        col_pos = 0;
        row_pos = 0;
        row_length_reg = ROW_LENGTH_RESET;
        row_count_reg = ROW_COUNT_RESET;
        foreach (window_cols[i])
            window_cols[i] = '0;
        foreach (upper_line[i])
        begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_min_grid();
        test_register_clamp();
        test_frame_restart();
        test_midframe_shrink();
        test_backpressure();
        test_wide_rows();
        test_tall_frame();
        test_random_frames();

        drain_results();
        repeat (20) @(posedge clk);
        $display("Covered %0d samples, %0d means checked, %0d completed frames.",
                 samples_sent, means_checked, frames_done);
        $display("Grids 3x3 up to 1024 wide, 65535-row setting, clamped registers, restarts, "
                 , "mid-frame shrink, long output hold-off.");
        if (mean_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
